>>> src/emtq_pkg.sv
`default_nettype none

package emtq_pkg;

  localparam int OP_W  = 3;
  localparam int ID_W  = 6;
  localparam int CID_W = 5;
  localparam int QM_W  = 32;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_KILL   = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_HAS    = 3'd4;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP,
    S_MODIFY,
    S_RESULT,
    S_QRD,
    S_QCHK,
    S_QEND
  } state_t;

  typedef enum logic [4:0] {
    A_NOP,
    A_LOAD,
    A_POP,
    A_ALLOC,
    A_FULL,
    A_ECHO,
    A_INVALID,
    A_READ,
    A_FILL,
    A_MODIFY,
    A_EMIT,
    A_QSTART,
    A_QREAD,
    A_QSKIP,
    A_QTAKE,
    A_QSWAP,
    A_QEND
  } act_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            stack_nonempty;
    logic            count_lt_max;
    logic            id_valid;
    logic            scan_done;
    logic            match;
    logic            pend_valid;
    logic            out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> src/emtq_ram.sv
`default_nettype none

module emtq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> src/emtq_ctrl.sv
`default_nettype none

module emtq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire emtq_pkg::stat_t stat,
  output emtq_pkg::act_t       act
);

  emtq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= emtq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      emtq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = emtq_pkg::S_DISPATCH;
        end
      end
      emtq_pkg::S_DISPATCH: begin
        case (stat.op)
          emtq_pkg::OP_CREATE: begin
            state_nxt = stat.stack_nonempty ? emtq_pkg::S_POP : emtq_pkg::S_RESULT;
          end
          emtq_pkg::OP_QUERY: begin
            state_nxt = emtq_pkg::S_QRD;
          end
          emtq_pkg::OP_KILL, emtq_pkg::OP_ADD, emtq_pkg::OP_REMOVE,
          emtq_pkg::OP_HAS: begin
            state_nxt = stat.id_valid ? emtq_pkg::S_MODIFY : emtq_pkg::S_RESULT;
          end
          default: begin
            state_nxt = emtq_pkg::S_RESULT;
          end
        endcase
      end
      emtq_pkg::S_POP: begin
        state_nxt = emtq_pkg::S_RESULT;
      end
      emtq_pkg::S_MODIFY: begin
        state_nxt = emtq_pkg::S_RESULT;
      end
      emtq_pkg::S_RESULT: begin
        if (stat.out_free) begin
          state_nxt = emtq_pkg::S_IDLE;
        end
      end
      emtq_pkg::S_QRD: begin
        state_nxt = stat.scan_done ? emtq_pkg::S_QEND : emtq_pkg::S_QCHK;
      end
      emtq_pkg::S_QCHK: begin
        if (!(stat.match && stat.pend_valid && !stat.out_free)) begin
          state_nxt = emtq_pkg::S_QRD;
        end
      end
      emtq_pkg::S_QEND: begin
        if (stat.out_free) begin
          state_nxt = emtq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = emtq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    act      = emtq_pkg::A_NOP;
    in_stall = (state_r != emtq_pkg::S_IDLE);
    case (state_r)
      emtq_pkg::S_IDLE: begin
        if (in_valid) begin
          act = emtq_pkg::A_LOAD;
        end
      end
      emtq_pkg::S_DISPATCH: begin
        case (stat.op)
          emtq_pkg::OP_CREATE: begin
            if (stat.stack_nonempty) begin
              act = emtq_pkg::A_POP;
            end else if (stat.count_lt_max) begin
              act = emtq_pkg::A_ALLOC;
            end else begin
              act = emtq_pkg::A_FULL;
            end
          end
          emtq_pkg::OP_QUERY: begin
            act = emtq_pkg::A_QSTART;
          end
          emtq_pkg::OP_KILL, emtq_pkg::OP_ADD, emtq_pkg::OP_REMOVE,
          emtq_pkg::OP_HAS: begin
            act = stat.id_valid ? emtq_pkg::A_READ : emtq_pkg::A_INVALID;
          end
          default: begin
            act = emtq_pkg::A_ECHO;
          end
        endcase
      end
      emtq_pkg::S_POP: begin
        act = emtq_pkg::A_FILL;
      end
      emtq_pkg::S_MODIFY: begin
        act = emtq_pkg::A_MODIFY;
      end
      emtq_pkg::S_RESULT: begin
        if (stat.out_free) begin
          act = emtq_pkg::A_EMIT;
        end
      end
      emtq_pkg::S_QRD: begin
        if (!stat.scan_done) begin
          act = emtq_pkg::A_QREAD;
        end
      end
      emtq_pkg::S_QCHK: begin
        if (!stat.match) begin
          act = emtq_pkg::A_QSKIP;
        end else if (!stat.pend_valid) begin
          act = emtq_pkg::A_QTAKE;
        end else if (stat.out_free) begin
          act = emtq_pkg::A_QSWAP;
        end
      end
      emtq_pkg::S_QEND: begin
        if (stat.out_free) begin
          act = emtq_pkg::A_QEND;
        end
      end
      default: begin
        act = emtq_pkg::A_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/emtq_dp.sv
`default_nettype none

module emtq_dp #(
  parameter int MAX_ENTITIES    = 64,
  parameter int COMPONENT_TYPES = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire emtq_pkg::act_t                act,
  output emtq_pkg::stat_t                    stat,
  input  wire logic [emtq_pkg::OP_W-1:0]     in_opcode,
  input  wire logic [emtq_pkg::ID_W-1:0]     in_entity_id,
  input  wire logic [emtq_pkg::CID_W-1:0]    in_component_id,
  input  wire logic [emtq_pkg::QM_W-1:0]     in_query_mask,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [emtq_pkg::ID_W-1:0]     out_result_id,
  output logic                               out_found,
  output logic      [emtq_pkg::ST_W-1:0]     out_status,
  output logic                               out_last
);

  localparam int AW    = $clog2(MAX_ENTITIES);
  localparam int CW    = $clog2(MAX_ENTITIES + 1);
  localparam int CT    = COMPONENT_TYPES;
  localparam int CMP_W = emtq_pkg::ID_W + 1;
  localparam int CIDX_W = emtq_pkg::CID_W + 1;

  logic [emtq_pkg::OP_W-1:0]  op_r, op_nxt;
  logic [emtq_pkg::ID_W-1:0]  eid_r, eid_nxt;
  logic [emtq_pkg::CID_W-1:0] cid_r, cid_nxt;
  logic [CT-1:0]              qmask_r, qmask_nxt;
  logic                       qm_ok_r, qm_ok_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              depth_r, depth_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic [AW-1:0]              pend_r, pend_nxt;
  logic                       pend_valid_r, pend_valid_nxt;
  logic [emtq_pkg::ID_W-1:0]  res_id_r, res_id_nxt;
  logic                       res_found_r, res_found_nxt;
  logic [emtq_pkg::ST_W-1:0]  res_status_r, res_status_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [emtq_pkg::ID_W-1:0]  out_id_r, out_id_nxt;
  logic                       out_found_r, out_found_nxt;
  logic [emtq_pkg::ST_W-1:0]  out_status_r, out_status_nxt;
  logic                       out_last_r, out_last_nxt;

  logic          mask_we, mask_re;
  logic [AW-1:0] mask_waddr, mask_raddr;
  logic [CT:0]   mask_wdata, mask_rdata;
  logic          stk_we, stk_re;
  logic [AW-1:0] stk_waddr, stk_raddr;
  logic [AW-1:0] stk_wdata, stk_rdata;

  logic [CW-1:0]         depth_dec;
  logic [AW-1:0]         eaddr;
  logic                  cid_ok;
  logic [emtq_pkg::QM_W-1:0] bit_full;
  logic [CT-1:0]         bitm;
  logic                  m_alive;
  logic [CT-1:0]         m_mask;
  logic                  out_free;

  emtq_ram #(.WIDTH(CT + 1), .DEPTH(MAX_ENTITIES)) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (mask_waddr),
    .wdata (mask_wdata),
    .re    (mask_re),
    .raddr (mask_raddr),
    .rdata (mask_rdata)
  );

  emtq_ram #(.WIDTH(AW), .DEPTH(MAX_ENTITIES)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign depth_dec = depth_r - CW'(1);
  assign eaddr     = eid_r[AW-1:0];
  assign cid_ok    = {1'b0, cid_r} < CIDX_W'(COMPONENT_TYPES);
  assign bit_full  = emtq_pkg::QM_W'(1) << cid_r;
  assign bitm      = cid_ok ? bit_full[CT-1:0] : '0;
  assign m_alive   = mask_rdata[CT];
  assign m_mask    = mask_rdata[CT-1:0];
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    stat.op             = op_r;
    stat.stack_nonempty = (depth_r != '0);
    stat.count_lt_max   = count_r < CW'(MAX_ENTITIES);
    stat.id_valid       = {1'b0, eid_r} < CMP_W'(count_r);
    stat.scan_done      = (idx_r == count_r);
    stat.match          = m_alive && qm_ok_r && ((m_mask & qmask_r) == qmask_r);
    stat.pend_valid     = pend_valid_r;
    stat.out_free       = out_free;
  end

  always_comb begin
    op_nxt         = op_r;
    eid_nxt        = eid_r;
    cid_nxt        = cid_r;
    qmask_nxt      = qmask_r;
    qm_ok_nxt      = qm_ok_r;
    count_nxt      = count_r;
    depth_nxt      = depth_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    res_id_nxt     = res_id_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_id_nxt     = out_id_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    mask_we        = 1'b0;
    mask_waddr     = eaddr;
    mask_wdata     = '0;
    mask_re        = 1'b0;
    mask_raddr     = eaddr;
    stk_we         = 1'b0;
    stk_waddr      = depth_r[AW-1:0];
    stk_wdata      = eaddr;
    stk_re         = 1'b0;
    stk_raddr      = depth_dec[AW-1:0];
    case (act)
      emtq_pkg::A_LOAD: begin
        op_nxt    = in_opcode;
        eid_nxt   = in_entity_id;
        cid_nxt   = in_component_id;
        qmask_nxt = in_query_mask[CT-1:0];
        qm_ok_nxt = (in_query_mask >> CT) == '0;
      end
      emtq_pkg::A_POP: begin
        stk_re    = 1'b1;
        depth_nxt = depth_dec;
      end
      emtq_pkg::A_ALLOC: begin
        mask_we        = 1'b1;
        mask_waddr     = count_r[AW-1:0];
        mask_wdata     = {1'b1, {CT{1'b0}}};
        count_nxt      = count_r + CW'(1);
        res_id_nxt     = emtq_pkg::ID_W'(count_r);
        res_found_nxt  = 1'b1;
        res_status_nxt = emtq_pkg::ST_OK;
      end
      emtq_pkg::A_FULL: begin
        res_id_nxt     = '0;
        res_found_nxt  = 1'b0;
        res_status_nxt = emtq_pkg::ST_FULL;
      end
      emtq_pkg::A_ECHO: begin
        res_id_nxt     = eid_r;
        res_found_nxt  = 1'b0;
        res_status_nxt = emtq_pkg::ST_OK;
      end
      emtq_pkg::A_INVALID: begin
        res_id_nxt     = eid_r;
        res_found_nxt  = 1'b0;
        res_status_nxt = emtq_pkg::ST_INVALID;
      end
      emtq_pkg::A_READ: begin
        mask_re = 1'b1;
      end
      emtq_pkg::A_FILL: begin
        mask_we        = 1'b1;
        mask_waddr     = stk_rdata;
        mask_wdata     = {1'b1, {CT{1'b0}}};
        res_id_nxt     = emtq_pkg::ID_W'(stk_rdata);
        res_found_nxt  = 1'b1;
        res_status_nxt = emtq_pkg::ST_OK;
      end
      emtq_pkg::A_MODIFY: begin
        res_id_nxt     = eid_r;
        res_found_nxt  = 1'b0;
        res_status_nxt = emtq_pkg::ST_OK;
        case (op_r)
          emtq_pkg::OP_KILL: begin
            if (m_alive) begin
              mask_we    = 1'b1;
              mask_wdata = '0;
              stk_we     = 1'b1;
              depth_nxt  = depth_r + CW'(1);
            end
          end
          emtq_pkg::OP_ADD: begin
            mask_we    = 1'b1;
            mask_wdata = {m_alive, m_mask | bitm};
          end
          emtq_pkg::OP_REMOVE: begin
            mask_we    = 1'b1;
            mask_wdata = {m_alive, m_mask & ~bitm};
          end
          emtq_pkg::OP_HAS: begin
            res_found_nxt = |(m_mask & bitm);
          end
          default: begin
            mask_we = 1'b0;
          end
        endcase
      end
      emtq_pkg::A_EMIT: begin
        out_valid_nxt  = 1'b1;
        out_id_nxt     = res_id_r;
        out_found_nxt  = res_found_r;
        out_status_nxt = res_status_r;
        out_last_nxt   = 1'b1;
      end
      emtq_pkg::A_QSTART: begin
        idx_nxt        = '0;
        pend_valid_nxt = 1'b0;
      end
      emtq_pkg::A_QREAD: begin
        mask_re    = 1'b1;
        mask_raddr = idx_r[AW-1:0];
      end
      emtq_pkg::A_QSKIP: begin
        idx_nxt = idx_r + CW'(1);
      end
      emtq_pkg::A_QTAKE: begin
        pend_nxt       = idx_r[AW-1:0];
        pend_valid_nxt = 1'b1;
        idx_nxt        = idx_r + CW'(1);
      end
      emtq_pkg::A_QSWAP: begin
        out_valid_nxt  = 1'b1;
        out_id_nxt     = emtq_pkg::ID_W'(pend_r);
        out_found_nxt  = 1'b1;
        out_status_nxt = emtq_pkg::ST_OK;
        out_last_nxt   = 1'b0;
        pend_nxt       = idx_r[AW-1:0];
        idx_nxt        = idx_r + CW'(1);
      end
      emtq_pkg::A_QEND: begin
        out_valid_nxt  = 1'b1;
        out_id_nxt     = pend_valid_r ? emtq_pkg::ID_W'(pend_r) : '0;
        out_found_nxt  = pend_valid_r;
        out_status_nxt = emtq_pkg::ST_OK;
        out_last_nxt   = 1'b1;
      end
      default: begin
        mask_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      depth_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      depth_r      <= depth_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    eid_r        <= eid_nxt;
    cid_r        <= cid_nxt;
    qmask_r      <= qmask_nxt;
    qm_ok_r      <= qm_ok_nxt;
    idx_r        <= idx_nxt;
    pend_r       <= pend_nxt;
    res_id_r     <= res_id_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    out_id_r     <= out_id_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_result_id = out_id_r;
  assign out_found     = out_found_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

>>> src/entity_mask_table_with_query_core.sv
// Create, kill, add, remove, has and unused opcodes go through dispatch, then a free stack
// pop or a mask modify where needed, to the result word; the next word is accepted after it.
// Query: each allocated id takes a read-then-check step of the loop on the single mask
// memory read port; output stalls hold the loop on a match to emit and hold the last word.
// Reset clears the id count, the free stack depth, the pending flag and the output valid;
// the mask, alive and free-id memories are not cleared and there is no clearing pass.
`default_nettype none

module entity_mask_table_with_query_core #(
  parameter int MAX_ENTITIES    = 64,
  parameter int COMPONENT_TYPES = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [emtq_pkg::OP_W-1:0]     in_opcode,
  input  wire logic [emtq_pkg::ID_W-1:0]     in_entity_id,
  input  wire logic [emtq_pkg::CID_W-1:0]    in_component_id,
  input  wire logic [emtq_pkg::QM_W-1:0]     in_query_mask,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [emtq_pkg::ID_W-1:0]     out_result_id,
  output logic                               out_found,
  output logic      [emtq_pkg::ST_W-1:0]     out_status,
  output logic                               out_last
);

  emtq_pkg::act_t  act;
  emtq_pkg::stat_t stat;

  emtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .act      (act)
  );

  emtq_dp #(
    .MAX_ENTITIES    (MAX_ENTITIES),
    .COMPONENT_TYPES (COMPONENT_TYPES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .act             (act),
    .stat            (stat),
    .in_opcode       (in_opcode),
    .in_entity_id    (in_entity_id),
    .in_component_id (in_component_id),
    .in_query_mask   (in_query_mask),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_id   (out_result_id),
    .out_found       (out_found),
    .out_status      (out_status),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire
